@@ rtl/core/astsm_pkg.sv @@
package astsm_pkg;

  // Reassembly buffer size in bytes; offsets and lengths are 11 bits wide
  localparam int BUFFER_BYTES = 1024;
  localparam int POS_W        = 11;
  localparam int SEQ_W        = 8;
  localparam int WIN_W        = 7;

  localparam logic [POS_W:0] BUF_LIMIT = (POS_W+1)'(BUFFER_BYTES);

  // PDU type upper nibble
  localparam logic [3:0] MODE_CONFIRMED   = 4'd0;
  localparam logic [3:0] MODE_UNCONFIRMED = 4'd1;
  localparam logic [3:0] MODE_SEGMENT_ACK = 4'd4;
  localparam logic [3:0] MODE_ABORT       = 4'd7;

  // PDU type low nibble bit positions
  localparam int FL_SEG_BIT = 3;
  localparam int FL_MOR_BIT = 2;
  localparam int FL_SRV_BIT = 0;

  localparam logic [7:0] DUP_LIMIT_RESET = 8'd2;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEGREQ = 3'b010,
    ST_AWAIT  = 3'b100
  } state_t;

  typedef enum logic [1:0] {
    RK_NONE  = 2'd0,
    RK_ACK   = 2'd1,
    RK_NAK   = 2'd2,
    RK_ABORT = 2'd3
  } reply_kind_t;

  typedef enum logic [3:0] {
    AR_NONE     = 4'd0,
    AR_OVERFLOW = 4'd1,
    AR_INVALID  = 4'd2,
    AR_WINDOW   = 4'd7
  } abort_reason_t;

  typedef struct packed {
    logic [3:0]       mode;
    logic [3:0]       pdu_flags;
    logic             broadcast_dest;
    logic [7:0]       inv_id;
    logic [SEQ_W-1:0] seg_seq;
    logic [7:0]       proposed_window;
    logic [POS_W-1:0] payload_length;
  } hdr_t;

  typedef struct packed {
    reply_kind_t      reply_kind;
    logic [7:0]       reply_inv_id;
    logic [SEQ_W-1:0] reply_seq;
    logic [WIN_W-1:0] reply_window;
    abort_reason_t    abort_reason;
    logic             store_segment;
    logic [POS_W-1:0] store_offset;
    logic             message_ready;
    logic [POS_W-1:0] message_length;
    logic             unconfirmed_ready;
  } res_t;

  typedef struct packed {
    state_t           state;
    logic [POS_W-1:0] wpos;
    logic [SEQ_W-1:0] init_seq;
    logic [SEQ_W-1:0] last_seq;
    logic [WIN_W-1:0] win;
    logic [7:0]       dup_count;
  } ctx_t;

  localparam ctx_t CTX_RESET = '{
    state:     ST_IDLE,
    wpos:      '0,
    init_seq:  '0,
    last_seq:  '0,
    win:       WIN_W'(1),
    dup_count: '0
  };

endpackage

@@ rtl/core/astsm_in_if.sv @@
interface astsm_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic [3:0]  pdu_flags;
  logic        broadcast_dest;
  logic [7:0]  inv_id;
  logic [7:0]  seg_seq;
  logic [7:0]  proposed_window;
  logic [10:0] payload_length;

  modport source (
    output valid, mode, pdu_flags, broadcast_dest, inv_id, seg_seq,
           proposed_window, payload_length,
    input  ready
  );

  modport sink (
    input  valid, mode, pdu_flags, broadcast_dest, inv_id, seg_seq,
           proposed_window, payload_length,
    output ready
  );
endinterface

@@ rtl/core/astsm_out_if.sv @@
interface astsm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reply_kind;
  logic [7:0]  reply_inv_id;
  logic [7:0]  reply_seq;
  logic [6:0]  reply_window;
  logic [3:0]  abort_reason;
  logic        store_segment;
  logic [10:0] store_offset;
  logic        message_ready;
  logic [10:0] message_length;
  logic        unconfirmed_ready;

  modport source (
    output valid, reply_kind, reply_inv_id, reply_seq, reply_window,
           abort_reason, store_segment, store_offset, message_ready,
           message_length, unconfirmed_ready,
    input  ready
  );

  modport sink (
    input  valid, reply_kind, reply_inv_id, reply_seq, reply_window,
           abort_reason, store_segment, store_offset, message_ready,
           message_length, unconfirmed_ready,
    output ready
  );
endinterface

@@ rtl/core/astsm_decide.sv @@
module astsm_decide (
  input  astsm_pkg::hdr_t   hdr,
  input  astsm_pkg::ctx_t   ctx,
  input  logic [7:0]        dup_limit,
  output astsm_pkg::ctx_t   ctx_nxt,
  output astsm_pkg::res_t   res
);
  import astsm_pkg::*;

  logic             seg;
  logic             more;
  logic             in_order;
  logic             group_end;
  logic [POS_W:0]   cont_sum;
  logic             start_over;
  logic             cont_over;
  logic [SEQ_W-1:0] got;
  logic [SEQ_W-1:0] ahead;
  logic [SEQ_W-1:0] behind;
  logic [SEQ_W-1:0] win_ext;
  logic             dup_hit;

  assign seg  = hdr.pdu_flags[FL_SEG_BIT];
  assign more = hdr.pdu_flags[FL_MOR_BIT];

  assign win_ext   = {1'b0, ctx.win};
  assign in_order  = (ctx.last_seq + SEQ_W'(1)) == hdr.seg_seq;
  assign group_end = (ctx.init_seq + win_ext) == hdr.seg_seq;

  // a new reassembly starts at offset zero, later segments at the write position
  assign cont_sum   = {1'b0, ctx.wpos} + {1'b0, hdr.payload_length};
  assign start_over = {1'b0, hdr.payload_length} > BUF_LIMIT;
  assign cont_over  = cont_sum > BUF_LIMIT;

  // modulo-256 duplicate window, first number init_seq
  assign got     = ctx.last_seq - ctx.init_seq;
  assign ahead   = hdr.seg_seq - ctx.init_seq;
  assign behind  = ctx.init_seq - hdr.seg_seq;
  assign dup_hit = (got <= win_ext) &&
                   ((ahead <= got) || ((got == '0) && (behind <= win_ext)));

  always_comb begin
    ctx_nxt = ctx;
    res     = '0;

    case (hdr.mode)
      MODE_CONFIRMED: begin
        if (hdr.broadcast_dest) begin
          ctx_nxt.state = ST_IDLE;
        end else if (seg && more) begin
          if (ctx.state != ST_SEGREQ) begin
            if (hdr.seg_seq != '0) begin
              ctx_nxt.state       = ST_IDLE;
              res.reply_kind      = RK_ABORT;
              res.reply_inv_id    = hdr.inv_id;
              res.abort_reason    = AR_INVALID;
            end else if (!(hdr.proposed_window inside {[8'd1:8'd127]})) begin
              ctx_nxt.state       = ST_IDLE;
              res.reply_kind      = RK_ABORT;
              res.reply_inv_id    = hdr.inv_id;
              res.abort_reason    = AR_WINDOW;
            end else begin
              ctx_nxt.wpos      = '0;
              ctx_nxt.init_seq  = '0;
              ctx_nxt.dup_count = '0;
              ctx_nxt.win       = WIN_W'(1);
              res.reply_inv_id  = hdr.inv_id;
              if (start_over) begin
                ctx_nxt.state    = ST_IDLE;
                res.reply_kind   = RK_ABORT;
                res.abort_reason = AR_OVERFLOW;
              end else begin
                ctx_nxt.state     = ST_SEGREQ;
                ctx_nxt.last_seq  = hdr.seg_seq;
                ctx_nxt.wpos      = hdr.payload_length;
                res.store_segment = 1'b1;
                res.reply_kind    = RK_ACK;
                res.reply_seq     = hdr.seg_seq;
                res.reply_window  = WIN_W'(1);
              end
            end
          end else if (in_order) begin
            if (cont_over) begin
              ctx_nxt.state       = ST_IDLE;
              res.reply_kind      = RK_ABORT;
              res.reply_inv_id    = hdr.inv_id;
              res.abort_reason    = AR_OVERFLOW;
            end else begin
              ctx_nxt.last_seq  = hdr.seg_seq;
              ctx_nxt.wpos      = cont_sum[POS_W-1:0];
              res.store_segment = 1'b1;
              res.store_offset  = ctx.wpos;
              if (group_end) begin
                ctx_nxt.init_seq    = hdr.seg_seq;
                res.reply_kind      = RK_ACK;
                res.reply_inv_id    = hdr.inv_id;
                res.reply_seq       = hdr.seg_seq;
                res.reply_window    = ctx.win;
              end
            end
          end else if (dup_hit && (ctx.dup_count < dup_limit)) begin
            ctx_nxt.dup_count = ctx.dup_count + 8'd1;
          end else begin
            ctx_nxt.dup_count   = '0;
            res.reply_kind      = RK_NAK;
            res.reply_inv_id    = hdr.inv_id;
            res.reply_seq       = ctx.last_seq;
            res.reply_window    = ctx.win;
          end
        end else if (seg) begin
          // final segment
          res.reply_inv_id = hdr.inv_id;
          if (ctx.state != ST_SEGREQ) begin
            ctx_nxt.state    = ST_IDLE;
            res.reply_kind   = RK_ABORT;
            res.abort_reason = AR_INVALID;
          end else if (!in_order) begin
            res.reply_kind   = RK_NAK;
            res.reply_seq    = ctx.last_seq;
            res.reply_window = ctx.win;
          end else if (cont_over) begin
            ctx_nxt.state    = ST_IDLE;
            res.reply_kind   = RK_ABORT;
            res.abort_reason = AR_OVERFLOW;
          end else begin
            ctx_nxt.state      = ST_AWAIT;
            ctx_nxt.last_seq   = hdr.seg_seq;
            ctx_nxt.wpos       = cont_sum[POS_W-1:0];
            res.store_segment  = 1'b1;
            res.store_offset   = ctx.wpos;
            res.message_ready  = 1'b1;
            res.message_length = cont_sum[POS_W-1:0];
            res.reply_kind     = RK_ACK;
            res.reply_seq      = hdr.seg_seq;
            res.reply_window   = ctx.win;
          end
        end else begin
          ctx_nxt.state      = ST_AWAIT;
          res.message_ready  = 1'b1;
          res.message_length = hdr.payload_length;
        end
      end
      MODE_UNCONFIRMED: begin
        res.unconfirmed_ready = 1'b1;
        res.message_length    = hdr.payload_length;
      end
      MODE_SEGMENT_ACK: begin
        // no segmented responses are sent, so a segment ack never fits
        ctx_nxt.state       = ST_IDLE;
        res.reply_kind      = RK_ABORT;
        res.reply_inv_id    = hdr.inv_id;
        res.abort_reason    = AR_INVALID;
      end
      MODE_ABORT: begin
        if (!hdr.pdu_flags[FL_SRV_BIT]) begin
          ctx_nxt.state = ST_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/apdu_segment_receive_tsm.sv @@
// Accepted headers sit in the input register, their results in the result register.
// Throughput: one header per cycle when the output is not stalled; the transaction
// context is updated in the decision stage as each header moves from the input
// register to the result register.
// Reset (rst_n low, synchronous): both stages empty, context idle with window 1,
// duplicate_limit back to 2.
module apdu_segment_receive_tsm (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  astsm_in_if.sink   in_bus,
  astsm_out_if.source out_bus
);
  import astsm_pkg::*;

  logic       in_vld_r;
  hdr_t       hdr_r;
  logic       out_vld_r;
  res_t       res_r;
  ctx_t       ctx_r;
  ctx_t       ctx_nxt;
  res_t       res_nxt;
  logic [7:0] dup_limit_r;
  logic       adv;
  logic       in_rdy;

  assign adv    = !out_vld_r || out_bus.ready;
  assign in_rdy = !in_vld_r || adv;

  assign in_bus.ready = in_rdy;

  astsm_decide u_decide (
    .hdr       (hdr_r),
    .ctx       (ctx_r),
    .dup_limit (dup_limit_r),
    .ctx_nxt   (ctx_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      ctx_r       <= CTX_RESET;
      dup_limit_r <= DUP_LIMIT_RESET;
    end else begin
      if (cfg_we) begin
        dup_limit_r <= cfg_wdata;
      end
      if (in_rdy) begin
        in_vld_r <= in_bus.valid;
      end
      if (adv) begin
        out_vld_r <= in_vld_r;
        if (in_vld_r) begin
          ctx_r <= ctx_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_bus.valid) begin
      hdr_r.mode            <= in_bus.mode;
      hdr_r.pdu_flags       <= in_bus.pdu_flags;
      hdr_r.broadcast_dest  <= in_bus.broadcast_dest;
      hdr_r.inv_id          <= in_bus.inv_id;
      hdr_r.seg_seq         <= in_bus.seg_seq;
      hdr_r.proposed_window <= in_bus.proposed_window;
      hdr_r.payload_length  <= in_bus.payload_length;
    end
    if (adv && in_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_bus.valid             = out_vld_r;
  assign out_bus.reply_kind        = res_r.reply_kind;
  assign out_bus.reply_inv_id      = res_r.reply_inv_id;
  assign out_bus.reply_seq         = res_r.reply_seq;
  assign out_bus.reply_window      = res_r.reply_window;
  assign out_bus.abort_reason      = res_r.abort_reason;
  assign out_bus.store_segment     = res_r.store_segment;
  assign out_bus.store_offset      = res_r.store_offset;
  assign out_bus.message_ready     = res_r.message_ready;
  assign out_bus.message_length    = res_r.message_length;
  assign out_bus.unconfirmed_ready = res_r.unconfirmed_ready;

`ifndef SYNTHESIS
  a_wpos_in_buffer: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, ctx_r.wpos} <= BUF_LIMIT)
    else $error("write position beyond reassembly buffer");

  a_abort_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && adv && res_nxt.reply_kind == RK_ABORT) |=> ctx_r.state == ST_IDLE)
    else $error("abort sent but context not idle");

  a_held_header_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !adv) |=> in_vld_r)
    else $error("stalled header dropped");

  a_offset_only_on_store: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !res_r.store_segment) |-> res_r.store_offset == '0)
    else $error("store offset set without a store");
`endif

endmodule

@@ sim/tb_top.sv @@
module tb_top;
  import astsm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int PHASE_BEATS = 150;

  typedef struct packed {
    hdr_t h;
    logic typed;
    res_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [7:0] cfg_wdata;

  astsm_in_if in_bus();
  astsm_out_if out_bus();

  apdu_segment_receive_tsm uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_bus(in_bus),
    .out_bus(out_bus)
  );

  // transaction context as the predictor sees it
  state_t tsm_state = ST_IDLE;
  int unsigned wr_pos = 0;
  logic [7:0] first_seq = 8'd0;
  logic [7:0] last_seq_r = 8'd0;
  logic [6:0] win = 7'd1;
  logic [7:0] dup_cnt = 8'd0;
  logic [7:0] dup_lim = DUP_LIMIT_RESET;

  res_t pending_replies[$];
  hdr_t pdu_q[$];
  dir_row_t dir_rows[$];

  int mismatch_cnt = 0;
  int reply_beats = 0;
  int unsigned cycle_cnt = 0;
  int send_pct = 0;
  int recv_pct = 0;
  logic [7:0] dup_settings [6] = '{8'd0, 8'd255, 8'd1, 8'd2, 8'd7, 8'd3};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic hdr_t pdu(logic [3:0] m, logic [3:0] f, logic b, logic [7:0] inv,
                               logic [7:0] sq, logic [7:0] pw, logic [10:0] len);
    hdr_t h;
    h.mode = m;
    h.pdu_flags = f;
    h.broadcast_dest = b;
    h.inv_id = inv;
    h.seg_seq = sq;
    h.proposed_window = pw;
    h.payload_length = len;
    return h;
  endfunction

  function automatic res_t typed_reply(reply_kind_t k, logic [7:0] inv, abort_reason_t why,
                                       logic mr, logic [10:0] ml, logic ur);
    res_t r;
    r = '0;
    r.reply_kind = k;
    r.reply_inv_id = inv;
    r.abort_reason = why;
    r.message_ready = mr;
    r.message_length = ml;
    r.unconfirmed_ready = ur;
    return r;
  endfunction

  function automatic void add_row(hdr_t h, logic typed, res_t want);
    dir_row_t row;
    row.h = h;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  function automatic res_t with_reply(res_t r, reply_kind_t k, logic [7:0] inv);
    r.reply_kind = k;
    r.reply_inv_id = inv;
    if (k == RK_ACK || k == RK_NAK) begin
      r.reply_seq = last_seq_r;
      r.reply_window = win;
    end
    return r;
  endfunction

  function automatic res_t abort_reply(logic [7:0] inv, abort_reason_t why);
    res_t r;
    tsm_state = ST_IDLE;
    r = with_reply('0, RK_ABORT, inv);
    r.abort_reason = why;
    return r;
  endfunction

  function automatic logic store_payload(hdr_t h, output res_t r);
    r = '0;
    if (wr_pos + h.payload_length > BUFFER_BYTES) begin
      r = abort_reply(h.inv_id, AR_OVERFLOW);
      return 1'b0;
    end
    last_seq_r = h.seg_seq;
    r.store_segment = 1'b1;
    r.store_offset = POS_W'(wr_pos);
    wr_pos += h.payload_length;
    return 1'b1;
  endfunction

  // modulo-256 window test starting at first_seq
  function automatic logic seq_is_duplicate(logic [7:0] s);
    logic [7:0] got;
    got = 8'(last_seq_r - first_seq);
    if (got > {1'b0, win}) return 1'b0;
    if (8'(s - first_seq) <= got) return 1'b1;
    if (got == 8'd0 && 8'(first_seq - s) <= {1'b0, win}) return 1'b1;
    return 1'b0;
  endfunction

  function automatic res_t predict_reply(hdr_t h);
    res_t r;
    logic [7:0] nxt;
    logic seg;
    logic more;
    r = '0;
    nxt = 8'(last_seq_r + 8'd1);
    seg = h.pdu_flags[FL_SEG_BIT];
    more = h.pdu_flags[FL_MOR_BIT];
    if (h.mode == MODE_CONFIRMED) begin
      if (h.broadcast_dest) begin
        tsm_state = ST_IDLE;
      end else if (seg && more) begin
        if (tsm_state != ST_SEGREQ) begin
          if (h.seg_seq != 8'd0) begin
            r = abort_reply(h.inv_id, AR_INVALID);
          end else if (h.proposed_window == 8'd0 || h.proposed_window > 8'd127) begin
            r = abort_reply(h.inv_id, AR_WINDOW);
          end else begin
            tsm_state = ST_SEGREQ;
            wr_pos = 0;
            first_seq = 8'd0;
            dup_cnt = 8'd0;
            win = 7'd1;
            if (store_payload(h, r)) r = with_reply(r, RK_ACK, h.inv_id);
          end
        end else if (h.seg_seq == nxt) begin
          if (store_payload(h, r)) begin
            // group boundary: ack and slide the window start
            if (8'(first_seq + win) == h.seg_seq) begin
              first_seq = h.seg_seq;
              r = with_reply(r, RK_ACK, h.inv_id);
            end
          end
        end else if (seq_is_duplicate(h.seg_seq) && dup_cnt < dup_lim) begin
          dup_cnt = 8'(dup_cnt + 8'd1);
        end else begin
          dup_cnt = 8'd0;
          r = with_reply(r, RK_NAK, h.inv_id);
        end
      end else if (seg) begin
        if (tsm_state != ST_SEGREQ) begin
          r = abort_reply(h.inv_id, AR_INVALID);
        end else if (h.seg_seq != nxt) begin
          r = with_reply(r, RK_NAK, h.inv_id);
        end else if (store_payload(h, r)) begin
          tsm_state = ST_AWAIT;
          r.message_ready = 1'b1;
          r.message_length = POS_W'(wr_pos);
          r = with_reply(r, RK_ACK, h.inv_id);
        end
      end else begin
        tsm_state = ST_AWAIT;
        r.message_ready = 1'b1;
        r.message_length = h.payload_length;
      end
    end else if (h.mode == MODE_UNCONFIRMED) begin
      r.unconfirmed_ready = 1'b1;
      r.message_length = h.payload_length;
    end else if (h.mode == MODE_SEGMENT_ACK) begin
      r = abort_reply(h.inv_id, AR_INVALID);
    end else if (h.mode == MODE_ABORT) begin
      if (!h.pdu_flags[FL_SRV_BIT]) tsm_state = ST_IDLE;
    end
    return r;
  endfunction

  task automatic flag_mismatch(string msg);
    mismatch_cnt++;
    $display("MISMATCH reply beat %0d: %s", reply_beats, msg);
  endtask

  task automatic check_field(string name, logic [10:0] got, logic [10:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic send_pdu(hdr_t h, logic typed, res_t want);
    res_t r;
    while ($urandom_range(99) < send_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.mode <= h.mode;
    in_bus.pdu_flags <= h.pdu_flags;
    in_bus.broadcast_dest <= h.broadcast_dest;
    in_bus.inv_id <= h.inv_id;
    in_bus.seg_seq <= h.seg_seq;
    in_bus.proposed_window <= h.proposed_window;
    in_bus.payload_length <= h.payload_length;
    do @(posedge clk); while (!in_bus.ready);
    r = predict_reply(h);
    pending_replies.push_back(typed ? want : r);
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_dup_limit(logic [7:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    dup_lim = v;
  endtask

  function automatic hdr_t noise_pdu();
    logic [3:0] m;
    int pick;
    pick = $urandom_range(9);
    if (pick < 3) m = MODE_CONFIRMED;
    else if (pick < 5) m = MODE_UNCONFIRMED;
    else if (pick < 6) m = MODE_SEGMENT_ACK;
    else if (pick < 8) m = MODE_ABORT;
    else m = 4'($urandom);
    return pdu(m, 4'($urandom), ($urandom_range(3) == 0), 8'($urandom),
               ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom), 8'($urandom),
               11'($urandom_range(0, 1476)));
  endfunction

  function automatic int seg_len(logic long_run);
    if (long_run) return $urandom_range(0, 3);
    if ($urandom_range(19) == 0) return $urandom_range(0, 1476);
    return $urandom_range(0, 150);
  endfunction

  // one segmented request, mostly in order, with duplicates, gaps and stray PDUs mixed in
  task automatic queue_session();
    int n;
    int i;
    int tot;
    int len;
    int pick;
    logic long_run;
    logic [7:0] s;
    logic [7:0] inv;
    long_run = ($urandom_range(19) == 0);
    n = long_run ? $urandom_range(260, 300) : $urandom_range(0, 10);
    inv = 8'($urandom);
    s = 8'd0;
    len = seg_len(long_run);
    tot = len;
    pdu_q.push_back(pdu(MODE_CONFIRMED, {2'b11, 2'($urandom)}, 1'b0, inv, 8'd0,
                        8'($urandom_range(1, 127)), 11'(len)));
    for (i = 1; i <= n + 1; i++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 4))
          pdu_q.push_back(pdu(MODE_CONFIRMED, {2'b11, 2'($urandom)}, 1'b0, inv,
                              8'(s - 8'($urandom_range(0, 1))), 8'($urandom),
                              11'(seg_len(long_run))));
      end else if (pick < 11) begin
        pdu_q.push_back(pdu(MODE_CONFIRMED, 4'b1100, 1'b0, inv,
                            8'(s + 8'($urandom_range(2, 9))), 8'($urandom), 11'd10));
      end else if (pick < 13) begin
        pdu_q.push_back(pdu(MODE_CONFIRMED, 4'b1000, 1'b0, inv,
                            8'(s + 8'($urandom_range(2, 9))), 8'($urandom), 11'd10));
      end else if (pick < 15) begin
        pdu_q.push_back(noise_pdu());
      end
      s = 8'(s + 8'd1);
      len = seg_len(long_run);
      if (i == n + 1 && $urandom_range(9) == 0 && tot <= BUFFER_BYTES) len = BUFFER_BYTES - tot;
      tot += len;
      pdu_q.push_back(pdu(MODE_CONFIRMED, {1'b1, (i <= n), 2'($urandom)}, 1'b0, inv, s,
                          8'($urandom), 11'(len)));
    end
  endtask

  always @(posedge clk) begin
    out_bus.ready <= rst_n && ($urandom_range(99) >= recv_pct);
  end

  always @(posedge clk) begin : watch_replies
    res_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      reply_beats++;
      if (pending_replies.size() == 0) begin
        flag_mismatch("reply beat with nothing expected");
      end else begin
        want = pending_replies.pop_front();
        check_field("reply_kind", 11'(out_bus.reply_kind), 11'(want.reply_kind));
        check_field("reply_inv_id", 11'(out_bus.reply_inv_id), 11'(want.reply_inv_id));
        check_field("reply_seq", 11'(out_bus.reply_seq), 11'(want.reply_seq));
        check_field("reply_window", 11'(out_bus.reply_window), 11'(want.reply_window));
        check_field("abort_reason", 11'(out_bus.abort_reason), 11'(want.abort_reason));
        check_field("store_segment", 11'(out_bus.store_segment), 11'(want.store_segment));
        check_field("store_offset", out_bus.store_offset, want.store_offset);
        check_field("message_ready", 11'(out_bus.message_ready), 11'(want.message_ready));
        check_field("message_length", out_bus.message_length, want.message_length);
        check_field("unconfirmed_ready", 11'(out_bus.unconfirmed_ready),
                    11'(want.unconfirmed_ready));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t row;
    hdr_t h;
    int p;
    int counted;

    cfg_we = 1'b0;
    cfg_wdata = 8'd0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.mode = 4'd0;
    in_bus.pdu_flags = 4'd0;
    in_bus.broadcast_dest = 1'b0;
    in_bus.inv_id = 8'd0;
    in_bus.seg_seq = 8'd0;
    in_bus.proposed_window = 8'd0;
    in_bus.payload_length = 11'd0;

    // unconfirmed at max length, plain confirmed at zero length, segment ack
    add_row(pdu(MODE_UNCONFIRMED, 4'h0, 1'b0, 8'h00, 8'h00, 8'h00, 11'd1476), 1'b1,
            typed_reply(RK_NONE, 8'h00, AR_NONE, 1'b0, 11'd1476, 1'b1));
    add_row(pdu(MODE_CONFIRMED, 4'h0, 1'b0, 8'hFF, 8'hFF, 8'hFF, 11'd0), 1'b1,
            typed_reply(RK_NONE, 8'h00, AR_NONE, 1'b1, 11'd0, 1'b0));
    add_row(pdu(MODE_SEGMENT_ACK, 4'hF, 1'b1, 8'hFF, 8'hFF, 8'hFF, 11'd1476), 1'b1,
            typed_reply(RK_ABORT, 8'hFF, AR_INVALID, 1'b0, 11'd0, 1'b0));
    // bad starts: nonzero sequence, window 0 and 128, final segment outside reassembly
    add_row(pdu(MODE_CONFIRMED, 4'hC, 1'b0, 8'h21, 8'd5, 8'd4, 11'd10), 1'b1,
            typed_reply(RK_ABORT, 8'h21, AR_INVALID, 1'b0, 11'd0, 1'b0));
    add_row(pdu(MODE_CONFIRMED, 4'hC, 1'b0, 8'h22, 8'd0, 8'd0, 11'd10), 1'b1,
            typed_reply(RK_ABORT, 8'h22, AR_WINDOW, 1'b0, 11'd0, 1'b0));
    add_row(pdu(MODE_CONFIRMED, 4'hF, 1'b0, 8'h23, 8'd0, 8'd128, 11'd10), 1'b1,
            typed_reply(RK_ABORT, 8'h23, AR_WINDOW, 1'b0, 11'd0, 1'b0));
    add_row(pdu(MODE_CONFIRMED, 4'h8, 1'b0, 8'h25, 8'd3, 8'd1, 11'd10), 1'b1,
            typed_reply(RK_ABORT, 8'h25, AR_INVALID, 1'b0, 11'd0, 1'b0));
    // broadcast confirmed: dropped silently
    add_row(pdu(MODE_CONFIRMED, 4'hC, 1'b1, 8'h26, 8'd0, 8'd1, 11'd10), 1'b1, '0);
    // reassembly with duplicates up to the limit, then NAKs and an overflow abort
    add_row(pdu(MODE_CONFIRMED, 4'hC, 1'b0, 8'h11, 8'd0, 8'd127, 11'd100), 1'b0, '0);
    add_row(pdu(MODE_CONFIRMED, 4'hC, 1'b0, 8'h11, 8'd1, 8'd127, 11'd200), 1'b0, '0);
    add_row(pdu(MODE_CONFIRMED, 4'hC, 1'b0, 8'h11, 8'd1, 8'd127, 11'd200), 1'b0, '0);
    add_row(pdu(MODE_CONFIRMED, 4'hC, 1'b0, 8'h11, 8'd1, 8'd127, 11'd200), 1'b0, '0);
    add_row(pdu(MODE_CONFIRMED, 4'hC, 1'b0, 8'h11, 8'd1, 8'd127, 11'd200), 1'b0, '0);
    add_row(pdu(MODE_CONFIRMED, 4'hC, 1'b0, 8'h11, 8'd0, 8'd127, 11'd100), 1'b0, '0);
    add_row(pdu(MODE_CONFIRMED, 4'hC, 1'b0, 8'h11, 8'd5, 8'd127, 11'd10), 1'b0, '0);
    add_row(pdu(MODE_CONFIRMED, 4'h8, 1'b0, 8'h11, 8'd7, 8'd127, 11'd10), 1'b0, '0);
    add_row(pdu(MODE_CONFIRMED, 4'hC, 1'b0, 8'h11, 8'd2, 8'd127, 11'd1000), 1'b1,
            typed_reply(RK_ABORT, 8'h11, AR_OVERFLOW, 1'b0, 11'd0, 1'b0));
    // exact buffer fill, abort PDUs with and without the server bit, unknown mode, oversized start
    add_row(pdu(MODE_CONFIRMED, 4'hC, 1'b0, 8'h40, 8'd0, 8'd1, 11'd1024), 1'b0, '0);
    add_row(pdu(MODE_CONFIRMED, 4'h8, 1'b0, 8'h40, 8'd1, 8'd1, 11'd0), 1'b0, '0);
    add_row(pdu(MODE_ABORT, 4'h1, 1'b0, 8'h40, 8'd0, 8'd0, 11'd0), 1'b1, '0);
    add_row(pdu(MODE_ABORT, 4'h0, 1'b0, 8'h40, 8'd0, 8'd0, 11'd0), 1'b1, '0);
    add_row(pdu(4'hF, 4'hF, 1'b1, 8'hFF, 8'hFF, 8'hFF, 11'd1476), 1'b1, '0);
    add_row(pdu(MODE_CONFIRMED, 4'hC, 1'b0, 8'h50, 8'd0, 8'd127, 11'd1476), 1'b1,
            typed_reply(RK_ABORT, 8'h50, AR_OVERFLOW, 1'b0, 11'd0, 1'b0));
    // unsegmented request arriving mid-reassembly, then a broadcast unconfirmed PDU
    add_row(pdu(MODE_CONFIRMED, 4'hC, 1'b0, 8'h60, 8'd0, 8'd64, 11'd10), 1'b0, '0);
    add_row(pdu(MODE_CONFIRMED, 4'h1, 1'b0, 8'h60, 8'd0, 8'd0, 11'd5), 1'b1,
            typed_reply(RK_NONE, 8'h00, AR_NONE, 1'b1, 11'd5, 1'b0));
    add_row(pdu(MODE_UNCONFIRMED, 4'h0, 1'b1, 8'h61, 8'd0, 8'd0, 11'd0), 1'b1,
            typed_reply(RK_NONE, 8'h00, AR_NONE, 1'b0, 11'd0, 1'b1));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pct = 28;
    recv_pct = 84;
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_pdu(row.h, row.typed, row.want);
    end

    for (p = 0; p < 6; p++) begin
      write_dup_limit(dup_settings[p]);
      case (p / 2)
        0: begin
          send_pct = 28;
          recv_pct = 84;
        end
        1: begin
          send_pct = 84;
          recv_pct = 28;
        end
        default: begin
          send_pct = 0;
          recv_pct = 0;
        end
      endcase
      counted = 0;
      while (counted < PHASE_BEATS) begin
        if ($urandom_range(9) < 7) queue_session();
        else repeat ($urandom_range(1, 4)) pdu_q.push_back(noise_pdu());
        while (pdu_q.size() != 0) begin
          h = pdu_q.pop_front();
          send_pdu(h, 1'b0, '0);
          if (h.mode == MODE_CONFIRMED || h.mode == MODE_UNCONFIRMED ||
              h.mode == MODE_SEGMENT_ACK || h.mode == MODE_ABORT) counted++;
        end
      end
    end

    drain();
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/astsm_pkg.sv
rtl/core/astsm_in_if.sv
rtl/core/astsm_out_if.sv
rtl/core/astsm_decide.sv
rtl/core/apdu_segment_receive_tsm.sv
sim/tb_top.sv
